@@ hdl/knap_pkg.sv @@
// ----------------------------------------------------------------------------
// knap_pkg
// Shared widths, limits and state codes of the 0/1 knapsack solver.
// ----------------------------------------------------------------------------
`default_nettype none

package knap_pkg;

  localparam int WEIGHT_W = 8;
  localparam int VALUE_W  = 16;
  localparam int TOTAL_W  = 21;
  localparam int INDEX_W  = 6;
  localparam int CAP_W    = 8;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam int DEF_MAX_ITEMS    = 32;
  localparam int DEF_MAX_CAPACITY = 255;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_TB_START,
    ST_TB_TOTAL,
    ST_TB_ISSUE,
    ST_TB_EVAL,
    ST_OUT_TOTAL,
    ST_OUT_SCAN
  } st_t;

endpackage

`default_nettype wire

@@ hdl/knap_in_if.sv @@
// ----------------------------------------------------------------------------
// knap_in_if
// Item channel: one word per item, weight, value and last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface knap_in_if;
  import knap_pkg::*;

  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] item_weight;
  logic [VALUE_W-1:0]  item_value;
  logic                last_item;

  modport source (output valid, output item_weight, output item_value,
                  output last_item, input ready);
  modport sink   (input valid, input item_weight, input item_value,
                  input last_item, output ready);
endinterface

`default_nettype wire

@@ hdl/knap_out_if.sv @@
// ----------------------------------------------------------------------------
// knap_out_if
// Result channel: one word per result, total or chosen item index.
// ----------------------------------------------------------------------------
`default_nettype none

interface knap_out_if;
  import knap_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_total;
  logic [TOTAL_W-1:0] best_total;
  logic [INDEX_W-1:0] chosen_index;
  logic               last_result;

  modport source (output valid, output is_total, output best_total,
                  output chosen_index, output last_result, input ready);
  modport sink   (input valid, input is_total, input best_total,
                  input chosen_index, input last_result, output ready);
endinterface

`default_nettype wire

@@ hdl/knap_ram.sv @@
// ----------------------------------------------------------------------------
// knap_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module knap_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/knapsack_01_dp_solver.sv @@
// ----------------------------------------------------------------------------
// knapsack_01_dp_solver
// 0/1 knapsack by dynamic programming over a best-value row held in RAM.
// ----------------------------------------------------------------------------
// Each item accepted on in_if sweeps the best-value row from MAX_CAPACITY
// down to 0, one read-modify-write of the row RAM per cycle, and writes one
// take bit per capacity. After the item marked last the block walks the take
// bits back, one stored item at a time, then sends the best total and the
// chosen indices in ascending order on out_if, at most one word per cycle
// while out_if.ready is high. After reset and after each answer a clearing
// pass zeroes the row; no item is taken during it. Items beyond MAX_ITEMS
// are dropped; their last mark still counts. capacity is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// as the block itself does not enforce this.
`default_nettype none

module knapsack_01_dp_solver #(
  parameter int MAX_ITEMS    = knap_pkg::DEF_MAX_ITEMS,
  parameter int MAX_CAPACITY = knap_pkg::DEF_MAX_CAPACITY
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [knap_pkg::CAP_W-1:0] cfg_wr_data,
  knap_in_if.sink                       in_if,
  knap_out_if.source                    out_if
);
  import knap_pkg::*;

  localparam int CW  = $clog2(MAX_CAPACITY + 1);
  localparam int EW  = (CW > CAP_W) ? CW : CAP_W;
  localparam int SW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int IW  = $clog2(MAX_ITEMS + 1);
  localparam int TAW = SW + CW;

  st_t state_r, state_nxt;

  logic [CAP_W-1:0]    capacity_r;
  logic [CW-1:0]       cap_eff;
  logic [CW-1:0]       cap_r, cap_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [CW-1:0]       clr_r, clr_nxt;
  logic [WEIGHT_W-1:0] w_r, w_nxt;
  logic [VALUE_W-1:0]  v_r, v_nxt;
  logic                last_r, last_nxt;
  logic [IW-1:0]       cnt_r, cnt_nxt;
  logic                p_vld_r, p_vld_nxt;
  logic                p_fit_r, p_fit_nxt;
  logic [CW-1:0]       p_j_r, p_j_nxt;
  logic [CW-1:0]       c_r, c_nxt;
  logic [IW-1:0]       i_r, i_nxt;
  logic [SW-1:0]       s_r, s_nxt;
  logic [MAX_ITEMS-1:0] flag_r, flag_nxt;
  logic                any_r, any_nxt;
  logic [INDEX_W-1:0]  max_r, max_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic               out_tot_r, out_tot_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic [INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic               out_last_r, out_last_nxt;

  logic               bra_we, tk_we, wt_we;
  logic [CW-1:0]      bra_waddr, bra_raddr, brb_raddr;
  logic [TOTAL_W-1:0] bra_wdata, bra_rdata, brb_rdata;
  logic [TAW-1:0]     tk_waddr, tk_raddr;
  logic               tk_wdata, tk_rdata;
  logic [SW-1:0]      wt_waddr, wt_raddr;
  logic [WEIGHT_W-1:0] wt_rdata;

  logic               accept, full, out_free, fit, take, scan_hit, scan_last;
  logic [EW-1:0]      cap_ext, j_ext, w_ext, c_ext, wt_ext;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] cand;
  logic [SW-1:0]      tb_slot;

  knap_ram #(.WIDTH(TOTAL_W), .ADDR_W(CW)) u_row_a (
    .clk, .wr_en(bra_we), .wr_addr(bra_waddr), .wr_data(bra_wdata),
    .rd_addr(bra_raddr), .rd_data(bra_rdata)
  );

  knap_ram #(.WIDTH(TOTAL_W), .ADDR_W(CW)) u_row_b (
    .clk, .wr_en(bra_we), .wr_addr(bra_waddr), .wr_data(bra_wdata),
    .rd_addr(brb_raddr), .rd_data(brb_rdata)
  );

  knap_ram #(.WIDTH(1), .ADDR_W(TAW)) u_take (
    .clk, .wr_en(tk_we), .wr_addr(tk_waddr), .wr_data(tk_wdata),
    .rd_addr(tk_raddr), .rd_data(tk_rdata)
  );

  knap_ram #(.WIDTH(WEIGHT_W), .ADDR_W(SW)) u_weight (
    .clk, .wr_en(wt_we), .wr_addr(wt_waddr), .wr_data(in_if.item_weight),
    .rd_addr(wt_raddr), .rd_data(wt_rdata)
  );

  assign in_if.ready         = (state_r == ST_IDLE);
  assign out_if.valid        = out_vld_r;
  assign out_if.is_total     = out_tot_r;
  assign out_if.best_total   = out_total_r;
  assign out_if.chosen_index = out_idx_r;
  assign out_if.last_result  = out_last_r;

  assign accept   = in_if.valid && (state_r == ST_IDLE);
  assign full     = (cnt_r >= IW'(MAX_ITEMS));
  assign out_free = !out_vld_r || out_if.ready;

  assign cap_ext = EW'(capacity_r);
  assign cap_eff = (cap_ext > EW'(MAX_CAPACITY)) ? CW'(MAX_CAPACITY) : CW'(cap_ext);

  assign j_ext = EW'(j_r);
  assign w_ext = EW'(w_r);
  assign fit   = (j_r != '0) && (j_r <= cap_r) && (j_ext >= w_ext);

  assign sum  = {1'b0, brb_rdata} + (TOTAL_W + 1)'(v_r);
  assign cand = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
  assign take = p_vld_r && p_fit_r && (cand > bra_rdata);

  assign c_ext   = EW'(c_r);
  assign wt_ext  = EW'(wt_rdata);
  assign tb_slot = SW'(i_r - IW'(1));

  assign scan_hit  = flag_r[s_r];
  assign scan_last = ((INDEX_W'(s_r) + INDEX_W'(1)) == max_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == CW'(MAX_CAPACITY)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (!full) state_nxt = ST_SWEEP;
          else if (in_if.last_item) state_nxt = ST_TB_START;
        end
      end
      ST_SWEEP: begin
        if (j_r == '0) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = last_r ? ST_TB_START : ST_IDLE;
      end
      ST_TB_START: state_nxt = ST_TB_TOTAL;
      ST_TB_TOTAL: state_nxt = ST_TB_ISSUE;
      ST_TB_ISSUE: begin
        state_nxt = (i_r == '0) ? ST_OUT_TOTAL : ST_TB_EVAL;
      end
      ST_TB_EVAL: state_nxt = ST_TB_ISSUE;
      ST_OUT_TOTAL: begin
        if (out_free) state_nxt = any_r ? ST_OUT_SCAN : ST_CLEAR;
      end
      ST_OUT_SCAN: begin
        if (scan_hit && out_free && scan_last) state_nxt = ST_CLEAR;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cap_nxt   = cap_r;
    j_nxt     = j_r;
    clr_nxt   = clr_r;
    w_nxt     = w_r;
    v_nxt     = v_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    p_vld_nxt = 1'b0;
    p_fit_nxt = fit;
    p_j_nxt   = j_r;
    c_nxt     = c_r;
    i_nxt     = i_r;
    s_nxt     = s_r;
    flag_nxt  = flag_r;
    any_nxt   = any_r;
    max_nxt   = max_r;
    total_nxt = total_r;

    out_vld_nxt   = out_if.ready ? 1'b0 : out_vld_r;
    out_tot_nxt   = out_tot_r;
    out_total_nxt = out_total_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    bra_we    = take;
    bra_waddr = p_j_r;
    bra_wdata = cand;
    bra_raddr = j_r;
    brb_raddr = CW'(j_ext - w_ext);
    tk_we     = p_vld_r;
    tk_waddr  = {SW'(cnt_r), p_j_r};
    tk_wdata  = take;
    tk_raddr  = {tb_slot, c_r};
    wt_we     = 1'b0;
    wt_waddr  = SW'(cnt_r);
    wt_raddr  = tb_slot;

    unique case (state_r)
      ST_CLEAR: begin
        bra_we    = 1'b1;
        bra_waddr = clr_r;
        bra_wdata = '0;
        clr_nxt   = clr_r + CW'(1);
        if (clr_r == CW'(MAX_CAPACITY)) cnt_nxt = '0;
      end
      ST_IDLE: begin
        if (accept) begin
          cap_nxt  = cap_eff;
          w_nxt    = in_if.item_weight;
          v_nxt    = in_if.item_value;
          last_nxt = in_if.last_item;
          j_nxt    = CW'(MAX_CAPACITY);
          wt_we    = !full;
        end
      end
      ST_SWEEP: begin
        p_vld_nxt = 1'b1;
        j_nxt     = j_r - CW'(1);
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + IW'(1);
      end
      ST_TB_START: begin
        bra_raddr = cap_r;
        c_nxt     = cap_r;
        i_nxt     = cnt_r;
        flag_nxt  = '0;
        any_nxt   = 1'b0;
        max_nxt   = '0;
      end
      ST_TB_TOTAL: begin
        total_nxt = bra_rdata;
      end
      ST_TB_ISSUE: begin
      end
      ST_TB_EVAL: begin
        if (tk_rdata) begin
          flag_nxt[tb_slot] = 1'b1;
          if (!any_r) begin
            any_nxt = 1'b1;
            max_nxt = INDEX_W'(i_r);
          end
          c_nxt = (wt_ext <= c_ext) ? CW'(c_ext - wt_ext) : '0;
        end
        i_nxt = i_r - IW'(1);
      end
      ST_OUT_TOTAL: begin
        if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_tot_nxt   = 1'b1;
          out_total_nxt = total_r;
          out_idx_nxt   = '0;
          out_last_nxt  = !any_r;
          s_nxt         = '0;
          clr_nxt       = '0;
        end
      end
      ST_OUT_SCAN: begin
        if (!scan_hit) begin
          s_nxt = s_r + SW'(1);
        end else if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_tot_nxt   = 1'b0;
          out_total_nxt = '0;
          out_idx_nxt   = INDEX_W'(s_r) + INDEX_W'(1);
          out_last_nxt  = scan_last;
          s_nxt         = s_r + SW'(1);
          clr_nxt       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      cnt_r      <= '0;
      p_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
      capacity_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      cnt_r     <= cnt_nxt;
      p_vld_r   <= p_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        capacity_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_r       <= cap_nxt;
    j_r         <= j_nxt;
    w_r         <= w_nxt;
    v_r         <= v_nxt;
    last_r      <= last_nxt;
    p_fit_r     <= p_fit_nxt;
    p_j_r       <= p_j_nxt;
    c_r         <= c_nxt;
    i_r         <= i_nxt;
    s_r         <= s_nxt;
    flag_r      <= flag_nxt;
    any_r       <= any_nxt;
    max_r       <= max_nxt;
    total_r     <= total_nxt;
    out_tot_r   <= out_tot_nxt;
    out_total_r <= out_total_nxt;
    out_idx_r   <= out_idx_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

@@ sim/knapsack_01_dp_solver_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knapsack_01_dp_solver_test
// Self-checking bench for the 0/1 knapsack solver.
// ----------------------------------------------------------------------------
// Items are queued per problem and sent in random bursts; the result channel
// stalls on its own pattern. A local dynamic-programming model solves each
// problem as its items are accepted and queues the expected answer words,
// which are compared field by field as they arrive. Capacity is changed only
// while the solver is quiet, including once in a while in the middle of a
// problem, and problems longer than the item slots are sent too.
// ----------------------------------------------------------------------------

module knapsack_01_dp_solver_test;
  import knap_pkg::*;

  localparam int N_SLOTS      = DEF_MAX_ITEMS;
  localparam int TOP_CAP      = DEF_MAX_CAPACITY;
  localparam int QUIET_CYCLES = 2 * (TOP_CAP + 3) + 2 * N_SLOTS + 64;
  localparam int STUCK_LIMIT  = 8000;
  localparam int RANDOM_ITEMS = 305;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } item_t;

  typedef struct packed {
    logic               is_total;
    logic [TOTAL_W-1:0] total;
    logic [INDEX_W-1:0] index;
    logic               last;
  } answer_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  knap_in_if  in_if ();
  knap_out_if out_if ();

  knapsack_01_dp_solver dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  item_t   pending_items[$];
  answer_t expected_answers[$];

  logic [TOTAL_W-1:0]  row_m [TOP_CAP+1];
  bit                  take_m [N_SLOTS][TOP_CAP+1];
  logic [WEIGHT_W-1:0] wt_m [N_SLOTS];
  int                  count_m;
  logic [CAP_W-1:0]    cap_m;

  int  errors;
  int  items_accepted;
  int  items_dropped;
  int  problems_solved;
  int  words_checked;
  int  cap_writes;
  int  stuck_cycles;
  bit  in_taken;
  bit  idle_on;
  int  stall_mode;
  int  gap_left;
  int  burst_left;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void solve_item(item_t it);
    int      cand;
    int      cap;
    int      c;
    int      n;
    int      slot;
    int      chosen [N_SLOTS];
    answer_t a;
    cap = (cap_m > TOP_CAP) ? TOP_CAP : cap_m;
    if (count_m < N_SLOTS) begin
      slot = count_m;
      wt_m[slot] = it.weight;
      take_m[slot][0] = 1'b0;
      for (int j = TOP_CAP; j >= 1; j--) begin
        take_m[slot][j] = 1'b0;
        if (j <= cap && j >= it.weight) begin
          cand = row_m[j - it.weight] + it.value;
          if (cand > TOTAL_MAX) cand = TOTAL_MAX;
          if (cand > row_m[j]) begin
            row_m[j] = cand;
            take_m[slot][j] = 1'b1;
          end
        end
      end
      count_m = slot + 1;
    end else begin
      items_dropped++;
    end
    if (!it.last) return;
    c = cap;
    n = 0;
    for (int i = count_m; i > 0; i--) begin
      if (take_m[i-1][c]) begin
        chosen[n] = i;
        n++;
        c = (wt_m[i-1] <= c) ? c - wt_m[i-1] : 0;
      end
    end
    a.is_total = 1'b1;
    a.total    = row_m[cap];
    a.index    = '0;
    a.last     = (n == 0);
    expected_answers.push_back(a);
    while (n > 0) begin
      n--;
      a.is_total = 1'b0;
      a.total    = '0;
      a.index    = chosen[n];
      a.last     = (n == 0);
      expected_answers.push_back(a);
    end
    for (int j = 0; j <= TOP_CAP; j++) row_m[j] = '0;
    count_m = 0;
    problems_solved++;
  endfunction

  // accept side: predict on input words, check output words
  always @(posedge clk) begin
    in_taken = rst_n && in_if.valid && in_if.ready;
    if (in_taken) begin
      solve_item(pending_items[0]);
      pending_items.pop_front();
      items_accepted++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result word: got total_flag=%0d total=%0d index=%0d last=%0d",
                 $time, out_if.is_total, out_if.best_total, out_if.chosen_index,
                 out_if.last_result);
        errors++;
      end else begin
        if (out_if.is_total !== expected_answers[0].is_total ||
            out_if.best_total !== expected_answers[0].total ||
            out_if.chosen_index !== expected_answers[0].index ||
            out_if.last_result !== expected_answers[0].last) begin
          $display("%0t: result mismatch: expected total_flag=%0d total=%0d index=%0d last=%0d",
                   $time, expected_answers[0].is_total, expected_answers[0].total,
                   expected_answers[0].index, expected_answers[0].last);
          $display("%0t:                  got      total_flag=%0d total=%0d index=%0d last=%0d",
                   $time, out_if.is_total, out_if.best_total, out_if.chosen_index,
                   out_if.last_result);
          errors++;
        end
        expected_answers.pop_front();
        words_checked++;
      end
    end
    if (in_taken || (out_if.valid && out_if.ready) || cfg_wr_en) stuck_cycles = 0;
    else stuck_cycles++;
  end

  // item driver: hold until taken, then advance in bursts with gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
    end else if (gap_left > 0) begin
      gap_left--;
      in_if.valid <= 1'b0;
    end else if (pending_items.size() != 0) begin
      in_if.item_weight <= pending_items[0].weight;
      in_if.item_value  <= pending_items[0].value;
      in_if.last_item   <= pending_items[0].last;
      in_if.valid       <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 6);
        if (!idle_on) gap_left = 0;
        else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(0, 300);
        else gap_left = $urandom_range(0, 4);
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // result receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_mode == 0) begin
      out_if.ready <= 1'b1;
    end else if (stall_mode == 1) begin
      out_if.ready <= ($urandom_range(0, 3) != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 40);
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  task automatic queue_item(int w, int v, bit last);
    item_t it;
    it.weight = w;
    it.value  = v;
    it.last   = last;
    pending_items.push_back(it);
  endtask

  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_if.valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(int c);
    wait_quiet();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cap_m = c;
    cap_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int pick_capacity();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return TOP_CAP;
      2, 3:    return $urandom_range(1, 30);
      default: return $urandom_range(1, TOP_CAP - 1);
    endcase
  endfunction

  task automatic queue_random(int n, bit ends_problem);
    int w;
    int v;
    int c;
    c = (cap_m == 0) ? 1 : cap_m;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: w = $urandom_range(1, c);
        6, 7:             w = $urandom_range(0, 255);
        8:                w = 0;
        default:          w = (c < 255) ? c + $urandom_range(0, 1) : c;
      endcase
      case ($urandom_range(0, 3))
        1:       v = $urandom_range(0, 20);
        2:       v = 65535 - $urandom_range(0, 15);
        default: v = $urandom_range(0, 65535);
      endcase
      queue_item(w, v, ends_problem && (k == n - 1));
    end
  endtask

  initial begin
    int sent;
    int len;
    int half;
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_if.valid       = 1'b0;
    in_if.item_weight = '0;
    in_if.item_value  = '0;
    in_if.last_item   = 1'b0;
    out_if.ready      = 1'b0;
    errors = 0;
    items_accepted = 0;
    items_dropped = 0;
    problems_solved = 0;
    words_checked = 0;
    cap_writes = 0;
    stuck_cycles = 0;
    in_taken = 1'b0;
    idle_on = 1'b0;
    stall_mode = 0;
    gap_left = 0;
    burst_left = 0;
    stall_left = 0;
    count_m = 0;
    cap_m = '0;
    for (int j = 0; j <= TOP_CAP; j++) row_m[j] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero capacity: nothing fits, even a weightless item
    queue_item(1, 5, 1'b0);
    queue_item(0, 7, 1'b1);

    set_capacity(TOP_CAP);
    stall_mode = 1;
    queue_item(255, 65535, 1'b0);
    queue_item(1, 0, 1'b0);
    queue_item(0, 100, 1'b0);
    queue_item(128, 40000, 1'b0);
    queue_item(127, 30000, 1'b1);
    queue_item(0, 65535, 1'b1);

    // item heavier than the limit: total alone
    set_capacity(10);
    queue_item(11, 999, 1'b1);

    // equal values: the later item does not strictly improve
    set_capacity(3);
    stall_mode = 2;
    queue_item(3, 10, 1'b0);
    queue_item(3, 10, 1'b1);

    // capacity lowered in the middle of a problem
    set_capacity(20);
    idle_on = 1'b1;
    queue_item(15, 300, 1'b0);
    queue_item(4, 50, 1'b0);
    set_capacity(5);
    queue_item(2, 20, 1'b0);
    queue_item(3, 25, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0 || $urandom_range(0, 2) == 0) set_capacity(pick_capacity());
      idle_on    = ($urandom_range(0, 3) != 0);
      stall_mode = $urandom_range(0, 2);
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(N_SLOTS + 1, N_SLOTS + 4);
        1:       len = N_SLOTS;
        default: len = $urandom_range(1, 10);
      endcase
      if (len > 4 && $urandom_range(0, 5) == 0) begin
        half = len / 2;
        queue_random(half, 1'b0);
        set_capacity(pick_capacity());
        queue_random(len - half, 1'b1);
      end else begin
        queue_random(len, 1'b1);
      end
      sent += len;
    end

    while (pending_items.size() != 0 || in_if.valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    if (expected_answers.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time,
               expected_answers.size());
      errors++;
    end
    $display("Covered %0d items (%0d past the slot limit) in %0d problems, %0d capacity writes.",
             items_accepted, items_dropped, problems_solved, cap_writes);
    $display("Checked %0d result words, %0d failures.", words_checked, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
